// ----- sv/zol_pkg.sv -----
`default_nettype none

package zol_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned OFS_W  = 18;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned NUM_W  = 10;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_TRANS = 3'd0,
    KIND_LOAD_OFS   = 3'd1,
    KIND_TO_LOCAL   = 3'd2,
    KIND_TO_UTC     = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_MERGED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_TYPE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CHK_LO,
    S_CHK_HI,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TYPE_RD,
    S_OFS,
    S_APPLY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic trans_we;
    logic ofs_we;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- sv/zol_arith.sv -----
`default_nettype none

module zol_arith (
  input  logic signed [zol_pkg::TIME_W-1:0] a_i,
  input  logic signed [zol_pkg::TIME_W-1:0] b_i,
  input  logic                              sub_i,
  output logic signed [zol_pkg::TIME_W-1:0] sum_o,
  output logic                              lt_o
);
  import zol_pkg::*;

  logic [TIME_W:0] a_ext;
  logic [TIME_W:0] b_ext;
  logic [TIME_W:0] b_op;
  logic [TIME_W:0] full;

  assign a_ext = {a_i[TIME_W-1], a_i};
  assign b_ext = {b_i[TIME_W-1], b_i};
  assign b_op  = b_ext ^ {(TIME_W+1){sub_i}};
  assign full  = a_ext + b_op + {{TIME_W{1'b0}}, sub_i};

  // exact sign of a - b in subtract mode
  assign lt_o = full[TIME_W];

  always_comb begin
    if (full[TIME_W] != full[TIME_W-1]) begin
      sum_o = full[TIME_W] ? TIME_MIN : TIME_MAX;
    end else begin
      sum_o = full[TIME_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/zol_store.sv -----
`default_nettype none

module zol_store #(
  parameter int unsigned  MAX_TRANSITIONS = 1024,
  parameter int unsigned  MAX_TYPES       = 256,
  localparam int unsigned TIDX_W          = $clog2(MAX_TRANSITIONS),
  localparam int unsigned OIDX_W          = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1
) (
  input  logic                               clk_i,
  input  zol_pkg::store_ctl_t                ctl_i,
  input  logic [TIDX_W-1:0]                  t_waddr_i,
  input  logic [TIDX_W-1:0]                  t_raddr_i,
  input  logic signed [zol_pkg::TIME_W-1:0]  time_wdata_i,
  input  logic [zol_pkg::TYPE_W-1:0]         type_wdata_i,
  input  logic [OIDX_W-1:0]                  o_waddr_i,
  input  logic [OIDX_W-1:0]                  o_raddr_i,
  input  logic signed [zol_pkg::OFS_W-1:0]   ofs_wdata_i,
  output logic signed [zol_pkg::TIME_W-1:0]  time_rdata_o,
  output logic [zol_pkg::TYPE_W-1:0]         type_rdata_o,
  output logic signed [zol_pkg::OFS_W-1:0]   ofs_rdata_o
);
  import zol_pkg::*;

  logic [TIME_W-1:0] time_mem [MAX_TRANSITIONS];
  logic [TYPE_W-1:0] type_mem [MAX_TRANSITIONS];
  logic [OFS_W-1:0]  ofs_mem  [MAX_TYPES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.trans_we) begin
      time_mem[t_waddr_i] <= time_wdata_i;
      type_mem[t_waddr_i] <= type_wdata_i;
    end
    time_rdata_o <= time_mem[t_raddr_i];
    type_rdata_o <= type_mem[t_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ofs_we) begin
      ofs_mem[o_waddr_i] <= ofs_wdata_i;
    end
    ofs_rdata_o <= ofs_mem[o_raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/zone_offset_lookup.sv -----
`default_nettype none

// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: stamp, type_index, type_offset; tuser: kind
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: result_time, offset_used,
//                                             transition_number, status
//
// one word in, one word out; a new word is taken only when the sequencer is idle
// loads, clear and unused kinds pass through exec and done from accept to output word,
// cache hits through chk_lo, chk_hi, apply and done; a table search over n entries
// takes a read step and a compare step per bisection step, split by the registered
// read of the time table; local to utc may search twice
// reset clears the entry count and the cached range; tables hold garbage until loaded
// a stalled output holds the finished word; the sequencer waits in its last step

module zone_offset_lookup #(
  parameter int unsigned MAX_TRANSITIONS = 1024,
  parameter int unsigned MAX_TYPES       = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] stamp, [71:64] type_index, [89:72] type_offset, [95:90] zero
  input  logic [zol_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [2:0] kind
  input  logic [zol_pkg::KIND_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] result_time, [81:64] offset_used, [91:82] transition_number,
  // [93:92] status, [95:94] zero
  output logic [zol_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import zol_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_TRANSITIONS + 1);
  localparam int unsigned TIDX_W = $clog2(MAX_TRANSITIONS);
  localparam int unsigned OIDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  state_e                   state_q, state_d;
  logic [KIND_W-1:0]        kind_q, kind_d;
  logic signed [TIME_W-1:0] stamp_q, stamp_d;
  logic [TYPE_W-1:0]        ty_q, ty_d;
  logic signed [OFS_W-1:0]  ofs_in_q, ofs_in_d;
  logic signed [TIME_W-1:0] query_q, query_d;
  logic                     pass_q, pass_d;
  logic                     below_q, below_d;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         hi_q, hi_d;
  logic [CNT_W-1:0]         mid_q, mid_d;
  logic                     hi_moved_q, hi_moved_d;
  logic signed [TIME_W-1:0] start_cand_q, start_cand_d;
  logic signed [TIME_W-1:0] end_cand_q, end_cand_d;
  logic signed [OFS_W-1:0]  used_q, used_d;
  logic [TIDX_W-1:0]        idx_q, idx_d;
  logic signed [TIME_W-1:0] res_q, res_d;
  status_e                  status_q, status_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [TYPE_W-1:0]        last_type_q, last_type_d;
  logic signed [TIME_W-1:0] range_start_q, range_start_d;
  logic signed [TIME_W-1:0] range_end_q, range_end_d;
  logic signed [OFS_W-1:0]  range_offset_q, range_offset_d;
  logic [TIDX_W-1:0]        range_index_q, range_index_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]    m_data_q, m_data_d;

  // shared unit and table ports
  logic signed [TIME_W-1:0] alu_a, alu_b, alu_sum;
  logic                     alu_sub, alu_lt;
  store_ctl_t               st_ctl;
  logic [TIDX_W-1:0]        t_raddr;
  logic [OIDX_W-1:0]        o_raddr;
  logic signed [TIME_W-1:0] time_rdata;
  logic [TYPE_W-1:0]        type_rdata;
  logic signed [OFS_W-1:0]  ofs_rdata;

  logic                     in_fire;
  logic                     ty_bad;
  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         lo_m1;
  logic signed [TIME_W-1:0] used_ext;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign ty_bad   = ({1'b0, ty_q} >= (TYPE_W+1)'(MAX_TYPES));
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign lo_m1    = lo_q - CNT_W'(1);
  assign used_ext = {{(TIME_W-OFS_W){used_q[OFS_W-1]}}, used_q};

  zol_arith u_arith (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  zol_store #(
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .MAX_TYPES       (MAX_TYPES)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (st_ctl),
    .t_waddr_i    (count_q[TIDX_W-1:0]),
    .t_raddr_i    (t_raddr),
    .time_wdata_i (stamp_q),
    .type_wdata_i (ty_q),
    .o_waddr_i    (ty_q[OIDX_W-1:0]),
    .o_raddr_i    (o_raddr),
    .ofs_wdata_i  (ofs_in_q),
    .time_rdata_o (time_rdata),
    .type_rdata_o (type_rdata),
    .ofs_rdata_o  (ofs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      range_start_q  <= '0;
      range_end_q    <= '0;
      range_offset_q <= '0;
      range_index_q  <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      range_start_q  <= range_start_d;
      range_end_q    <= range_end_d;
      range_offset_q <= range_offset_d;
      range_index_q  <= range_index_d;
      m_valid_q      <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    stamp_q      <= stamp_d;
    ty_q         <= ty_d;
    ofs_in_q     <= ofs_in_d;
    query_q      <= query_d;
    pass_q       <= pass_d;
    below_q      <= below_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    hi_moved_q   <= hi_moved_d;
    start_cand_q <= start_cand_d;
    end_cand_q   <= end_cand_d;
    used_q       <= used_d;
    idx_q        <= idx_d;
    res_q        <= res_d;
    status_q     <= status_d;
    last_type_q  <= last_type_d;
    m_data_q     <= m_data_d;
  end

  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    stamp_d        = stamp_q;
    ty_d           = ty_q;
    ofs_in_d       = ofs_in_q;
    query_d        = query_q;
    pass_d         = pass_q;
    below_d        = below_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    hi_moved_d     = hi_moved_q;
    start_cand_d   = start_cand_q;
    end_cand_d     = end_cand_q;
    used_d         = used_q;
    idx_d          = idx_q;
    res_d          = res_q;
    status_d       = status_q;
    count_d        = count_q;
    last_type_d    = last_type_q;
    range_start_d  = range_start_q;
    range_end_d    = range_end_q;
    range_offset_d = range_offset_q;
    range_index_d  = range_index_q;
    m_valid_d      = m_valid_q;
    m_data_d       = m_data_q;

    alu_a   = query_q;
    alu_b   = range_start_q;
    alu_sub = 1'b1;
    st_ctl  = '0;
    t_raddr = '0;
    o_raddr = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d   = s_axis_tuser;
          stamp_d  = s_axis_tdata[TIME_W-1:0];
          ty_d     = s_axis_tdata[TIME_W +: TYPE_W];
          ofs_in_d = s_axis_tdata[TIME_W+TYPE_W +: OFS_W];
          query_d  = s_axis_tdata[TIME_W-1:0];
          pass_d   = 1'b0;
          used_d   = '0;
          idx_d    = '0;
          res_d    = '0;
          status_d = ST_OK;
          if (s_axis_tuser == KIND_TO_LOCAL || s_axis_tuser == KIND_TO_UTC) begin
            state_d = S_CHK_LO;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        case (kind_q)
          KIND_LOAD_TRANS: begin
            if (ty_bad) begin
              status_d = ST_BAD_TYPE;
            end else if (count_q != '0 && last_type_q == ty_q) begin
              status_d = ST_MERGED;
            end else if (count_q == CNT_W'(MAX_TRANSITIONS)) begin
              status_d = ST_FULL;
            end else begin
              st_ctl.trans_we = 1'b1;
              count_d         = count_q + CNT_W'(1);
              last_type_d     = ty_q;
            end
          end
          KIND_LOAD_OFS: begin
            if (ty_bad) begin
              status_d = ST_BAD_TYPE;
            end else begin
              st_ctl.ofs_we = 1'b1;
            end
          end
          KIND_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
        // loads and clear empty the cached range
        if (kind_q == KIND_LOAD_TRANS || kind_q == KIND_LOAD_OFS || kind_q == KIND_CLEAR) begin
          range_start_d  = '0;
          range_end_d    = '0;
          range_offset_d = '0;
          range_index_d  = '0;
        end
        state_d = S_DONE;
      end

      S_CHK_LO: begin
        below_d = alu_lt;
        state_d = S_CHK_HI;
      end

      S_CHK_HI: begin
        alu_b = range_end_q;
        if (!below_q && alu_lt) begin
          used_d  = range_offset_q;
          idx_d   = range_index_q;
          state_d = S_APPLY;
        end else if (count_q == '0) begin
          range_start_d = TIME_MIN;
          range_end_d   = TIME_MAX;
          range_index_d = '0;
          idx_d         = '0;
          o_raddr       = '0;
          state_d       = S_OFS;
        end else begin
          lo_d       = '0;
          hi_d       = count_q;
          hi_moved_d = 1'b0;
          state_d    = S_SRCH_RD;
        end
      end

      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[CNT_W:1];
          t_raddr = mid_sum[TIDX_W:1];
          state_d = S_SRCH_CMP;
        end else begin
          // start and end are the last probed times on either side, else the extremes
          if (lo_q == '0) begin
            idx_d         = '0;
            range_start_d = TIME_MIN;
          end else begin
            idx_d         = lo_m1[TIDX_W-1:0];
            range_start_d = start_cand_q;
          end
          range_end_d   = hi_moved_q ? end_cand_q : TIME_MAX;
          range_index_d = (lo_q == '0) ? '0 : lo_m1[TIDX_W-1:0];
          t_raddr       = (lo_q == '0) ? '0 : lo_m1[TIDX_W-1:0];
          state_d       = S_TYPE_RD;
        end
      end

      S_SRCH_CMP: begin
        alu_b = time_rdata;
        if (alu_lt) begin
          hi_d       = mid_q;
          end_cand_d = time_rdata;
          hi_moved_d = 1'b1;
        end else begin
          lo_d         = mid_q + CNT_W'(1);
          start_cand_d = time_rdata;
        end
        state_d = S_SRCH_RD;
      end

      S_TYPE_RD: begin
        o_raddr = type_rdata[OIDX_W-1:0];
        state_d = S_OFS;
      end

      S_OFS: begin
        range_offset_d = ofs_rdata;
        used_d         = ofs_rdata;
        state_d        = S_APPLY;
      end

      S_APPLY: begin
        alu_a   = stamp_q;
        alu_b   = used_ext;
        alu_sub = (kind_q == KIND_TO_UTC);
        if (kind_q == KIND_TO_UTC && !pass_q && used_q != '0) begin
          // second lookup at t - o(t)
          query_d = alu_sum;
          pass_d  = 1'b1;
          state_d = S_CHK_LO;
        end else begin
          res_d   = alu_sum;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OUT_DATA_W-TIME_W-OFS_W-NUM_W-STAT_W){1'b0}},
                       status_q, NUM_W'(idx_q), used_q, res_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("output word loaded outside the final step");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TRANSITIONS))
    else $error("entry count beyond table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search bounds out of order");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_CMP) |-> (mid_q >= lo_q && mid_q < hi_q))
    else $error("probe outside search bounds");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
    else $error("accepted word left sequencer idle");

endmodule

`default_nettype wire
